### hw/rtl/rtpfu_pkg.sv
// Shared types and constants of the H.264 FU-A RTP packetizer.
`default_nettype none

package rtpfu_pkg;

    localparam int FRAME_LENGTH_WIDTH = 20;
    localparam int QUEUE_DEPTH        = 4;
    localparam int CFG_DATA_WIDTH     = 32;
    localparam int MIN_FRAME_BYTES    = 5;

    localparam logic [10:0] MIN_PAYLOAD   = 11'd64;
    localparam logic [10:0] MAX_PAYLOAD   = 11'd1460;
    localparam logic [10:0] RTP_HDR_BYTES = 11'd12;
    localparam logic [10:0] FU_HDR_BYTES  = 11'd2;

    localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0] FU_INDICATOR     = 8'h7C;
    localparam logic [7:0] FU_TYPE_MASK     = 8'h1F;
    localparam logic [7:0] FU_START         = 8'h80;
    localparam logic [7:0] FU_END           = 8'h40;

    localparam logic [1:0] CFG_MAX_PAYLOAD  = 2'd0;
    localparam logic [1:0] CFG_TS_INCREMENT = 2'd1;
    localparam logic [1:0] CFG_SSRC         = 2'd2;
    localparam logic [1:0] CFG_PAYLOAD_TYPE = 2'd3;

    localparam logic [10:0] RST_MAX_PAYLOAD  = 11'd1300;
    localparam logic [31:0] RST_TS_INCREMENT = 32'd3750;
    localparam logic [31:0] RST_SSRC         = 32'h98765432;
    localparam logic [6:0]  RST_PAYLOAD_TYPE = 7'd96;

    typedef struct packed {
        logic [7:0]                    in_byte;
        logic                          frame_start;
        logic [FRAME_LENGTH_WIDTH-1:0] frame_length;
    } rtpfu_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        packet_last;
        logic [10:0] packet_length;
    } rtpfu_out_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        hdr;
        logic        fu;
        logic [7:0]  fu_hdr;
        logic        last;
        logic [10:0] pkt_len;
        logic [15:0] seq;
        logic [31:0] ts;
    } rtpfu_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/rtp_h264_fu_a_packetizer.sv
// Top level of the H.264 FU-A RTP packetizer with its configuration registers.
//
// Frame bytes enter one per cycle unless the queue is full; the front end
// drops the start code and turns the other bytes, bar a fragmented frame's
// NAL header, into requests that a four-entry queue hands to the back end,
// which sends one packet byte per cycle unless stalled. A byte that opens a
// packet expands into 13 output bytes (15 for an FU-A fragment), so the
// input stalls at each packet start once the queue fills; the user writes
// configuration registers through the plain write port while the block is idle (not enforced by the block).
`default_nettype none

module rtp_h264_fu_a_packetizer
    import rtpfu_pkg::*;
#(
    parameter int LENGTH_BITS = 20
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire rtpfu_in_t                 in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output rtpfu_out_t                     out_data,
    input  wire logic                      cfg_wr_en,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data
);

    logic [10:0] max_payload_reg;
    logic [31:0] ts_increment_reg;
    logic [31:0] ssrc_reg;
    logic [6:0]  payload_type_reg;

    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_valid;
    rtpfu_cmd_t  q_in;
    rtpfu_cmd_t  q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg  <= RST_MAX_PAYLOAD;
            ts_increment_reg <= RST_TS_INCREMENT;
            ssrc_reg         <= RST_SSRC;
            payload_type_reg <= RST_PAYLOAD_TYPE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MAX_PAYLOAD:  max_payload_reg  <= cfg_data[10:0];
                CFG_TS_INCREMENT: ts_increment_reg <= cfg_data[31:0];
                CFG_SSRC:         ssrc_reg         <= cfg_data[31:0];
                CFG_PAYLOAD_TYPE: payload_type_reg <= cfg_data[6:0];
                default:          ;
            endcase
        end
    end

    rtpfu_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .max_payload  (max_payload_reg),
        .ts_increment (ts_increment_reg),
        .q_full       (q_full),
        .push         (q_push),
        .cmd          (q_in)
    );

    rtpfu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .q_valid   (q_valid),
        .head      (q_head)
    );

    rtpfu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .head         (q_head),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .payload_type (payload_type_reg),
        .ssrc         (ssrc_reg)
    );

endmodule

`default_nettype wire

### hw/rtl/rtpfu_front.sv
// Front end: strips the start code, tracks packet and fragment bounds, queues byte requests.
`default_nettype none

module rtpfu_front
    import rtpfu_pkg::*;
#(
    parameter int LENGTH_BITS = 20
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire rtpfu_in_t   in_data,
    input  wire logic [10:0] max_payload,
    input  wire logic [31:0] ts_increment,
    input  wire logic        q_full,
    output logic             push,
    output rtpfu_cmd_t       cmd
);

    localparam int LB = LENGTH_BITS;

    logic          active_reg,   active_next;
    logic [LB-1:0] frame_len_reg, frame_len_next;
    logic [LB-1:0] idx_reg,      idx_next;
    logic [1:0]    zeros_reg,    zeros_next;
    logic          start4_reg,   start4_next;
    logic [7:0]    nal_reg,      nal_next;
    logic          frag_reg,     frag_next;
    logic          first_reg,    first_next;
    logic [10:0]   pbc_reg,      pbc_next;
    logic [LB-1:0] pleft_reg,    pleft_next;
    logic [10:0]   pkt_len_reg,  pkt_len_next;
    logic [15:0]   seq_reg,      seq_next;
    logic [31:0]   ts_reg,       ts_next;

    logic          fire;
    logic [10:0]   mp;

    assign in_ready = !q_full;
    assign fire     = in_valid && !q_full;

    always_comb
    begin
        if (max_payload < MIN_PAYLOAD)
        begin
            mp = MIN_PAYLOAD;
        end
        else if (max_payload > MAX_PAYLOAD)
        begin
            mp = MAX_PAYLOAD;
        end
        else
        begin
            mp = max_payload;
        end
    end

    always_comb
    begin
        logic [LB-1:0] len_in;
        logic [LB-1:0] idx;
        logic [LB-1:0] fs;
        logic [2:0]    start_len;
        logic [10:0]   chunk;
        logic [7:0]    fu_hdr;
        logic [7:0]    b;
        logic          work;
        logic          emit_hdr;
        logic          emit_fu;
        logic          emit_pay;
        logic          last;

        len_in    = LB'(in_data.frame_length);
        b         = in_data.in_byte;
        idx       = '0;
        fs        = '0;
        start_len = 3'd3;
        chunk     = '0;
        fu_hdr    = '0;
        work      = 1'b0;
        emit_hdr  = 1'b0;
        emit_fu   = 1'b0;
        emit_pay  = 1'b0;
        last      = 1'b0;

        active_next    = active_reg;
        frame_len_next = frame_len_reg;
        idx_next       = idx_reg;
        zeros_next     = zeros_reg;
        start4_next    = start4_reg;
        nal_next       = nal_reg;
        frag_next      = frag_reg;
        first_next     = first_reg;
        pbc_next       = pbc_reg;
        pleft_next     = pleft_reg;
        pkt_len_next   = pkt_len_reg;
        seq_next       = seq_reg;
        ts_next        = ts_reg;
        push           = 1'b0;
        cmd            = '0;

        if (fire)
        begin
            if (in_data.frame_start)
            begin
                if (len_in < LB'(MIN_FRAME_BYTES))
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    work           = 1'b1;
                    frame_len_next = len_in;
                    idx_next       = '0;
                    zeros_next     = '0;
                    start4_next    = 1'b0;
                    frag_next      = 1'b0;
                    first_next     = 1'b0;
                    pbc_next       = '0;
                    pleft_next     = '0;
                    pkt_len_next   = '0;
                end
            end
            else if (active_reg)
            begin
                work = 1'b1;
            end
        end

        if (work)
        begin
            idx       = idx_next;
            start_len = start4_next ? 3'd4 : 3'd3;
            fs        = frame_len_next - LB'(start_len);

            if (idx < LB'(3))
            begin
                if (b == 8'h00 && zeros_next == idx[1:0])
                begin
                    zeros_next = zeros_next + 2'd1;
                end
            end
            else if (idx == LB'(3) && zeros_next == 2'd3 && b == 8'h01)
            begin
                start4_next = 1'b1;
            end
            else if (idx == LB'(start_len))
            begin
                nal_next = b;
                if (fs <= LB'(mp))
                begin
                    frag_next    = 1'b0;
                    pkt_len_next = RTP_HDR_BYTES + fs[10:0];
                    pbc_next     = fs[10:0];
                    emit_hdr     = 1'b1;
                    emit_pay     = 1'b1;
                end
                else
                begin
                    frag_next  = 1'b1;
                    first_next = 1'b1;
                    pleft_next = fs - LB'(1);
                    pbc_next   = '0;
                end
            end
            else if (!frag_next)
            begin
                if (pbc_next != '0)
                begin
                    emit_pay = 1'b1;
                end
            end
            else if (pleft_next != '0)
            begin
                if (pbc_next == '0)
                begin
                    chunk  = (pleft_next < LB'(mp)) ? pleft_next[10:0] : mp;
                    fu_hdr = nal_next & FU_TYPE_MASK;
                    if (first_next)
                    begin
                        fu_hdr = fu_hdr | FU_START;
                    end
                    else if (LB'(chunk) == pleft_next)
                    begin
                        fu_hdr = fu_hdr | FU_END;
                    end
                    first_next   = 1'b0;
                    pkt_len_next = RTP_HDR_BYTES + FU_HDR_BYTES + chunk;
                    pbc_next     = chunk;
                    emit_hdr     = 1'b1;
                    emit_fu      = 1'b1;
                end
                pleft_next = pleft_next - LB'(1);
                emit_pay   = 1'b1;
            end

            if (emit_pay)
            begin
                if (pbc_next != '0)
                begin
                    pbc_next = pbc_next - 11'd1;
                end
                last        = (pbc_next == '0);
                push        = 1'b1;
                cmd.data    = b;
                cmd.hdr     = emit_hdr;
                cmd.fu      = emit_fu;
                cmd.fu_hdr  = fu_hdr;
                cmd.last    = last;
                cmd.pkt_len = pkt_len_next;
                cmd.seq     = seq_reg;
                cmd.ts      = ts_reg;
                if (last)
                begin
                    seq_next = seq_reg + 16'd1;
                end
            end

            idx_next = idx + LB'(1);
            if (({1'b0, idx} + {{LB{1'b0}}, 1'b1}) >= {1'b0, frame_len_next})
            begin
                active_next = 1'b0;
                ts_next     = ts_reg + ts_increment;
            end
            else
            begin
                active_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            frame_len_reg <= '0;
            idx_reg       <= '0;
            zeros_reg     <= '0;
            start4_reg    <= 1'b0;
            nal_reg       <= '0;
            frag_reg      <= 1'b0;
            first_reg     <= 1'b0;
            pbc_reg       <= '0;
            pleft_reg     <= '0;
            pkt_len_reg   <= '0;
            seq_reg       <= '0;
            ts_reg        <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            frame_len_reg <= frame_len_next;
            idx_reg       <= idx_next;
            zeros_reg     <= zeros_next;
            start4_reg    <= start4_next;
            nal_reg       <= nal_next;
            frag_reg      <= frag_next;
            first_reg     <= first_next;
            pbc_reg       <= pbc_next;
            pleft_reg     <= pleft_next;
            pkt_len_reg   <= pkt_len_next;
            seq_reg       <= seq_next;
            ts_reg        <= ts_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rtpfu_queue.sv
// Short request queue between the front end and the packet byte emitter.
`default_nettype none

module rtpfu_queue
    import rtpfu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire rtpfu_cmd_t push_data,
    input  wire logic       pop,
    output logic            full,
    output logic            q_valid,
    output rtpfu_cmd_t      head
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    rtpfu_cmd_t            slots_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg,  count_next;

    assign full    = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rtpfu_back.sv
// Back end: emits each queued request's payload byte, led by the RTP header and FU bytes when flagged.
`default_nettype none

module rtpfu_back
    import rtpfu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire rtpfu_cmd_t  head,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output rtpfu_out_t       out_data,
    input  wire logic [6:0]  payload_type,
    input  wire logic [31:0] ssrc
);

    localparam logic [3:0] POS_VERSION = 4'd0;
    localparam logic [3:0] POS_PT      = 4'd1;
    localparam logic [3:0] POS_SEQ_HI  = 4'd2;
    localparam logic [3:0] POS_SEQ_LO  = 4'd3;
    localparam logic [3:0] POS_TS_3    = 4'd4;
    localparam logic [3:0] POS_TS_2    = 4'd5;
    localparam logic [3:0] POS_TS_1    = 4'd6;
    localparam logic [3:0] POS_TS_0    = 4'd7;
    localparam logic [3:0] POS_SSRC_3  = 4'd8;
    localparam logic [3:0] POS_SSRC_2  = 4'd9;
    localparam logic [3:0] POS_SSRC_1  = 4'd10;
    localparam logic [3:0] POS_SSRC_0  = 4'd11;
    localparam logic [3:0] POS_FU_IND  = 4'd12;
    localparam logic [3:0] POS_FU_HDR  = 4'd13;
    localparam logic [3:0] POS_PAYLOAD = 4'd14;

    logic       busy_reg, busy_next;
    logic [3:0] pos_reg,  pos_next;
    rtpfu_cmd_t cmd_reg,  cmd_next;
    logic       out_fire;
    logic       at_payload;

    assign out_valid  = busy_reg;
    assign out_fire   = busy_reg && out_ready;
    assign at_payload = (pos_reg == POS_PAYLOAD);
    assign pop        = q_valid && (!busy_reg || (out_fire && at_payload));

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        cmd_next  = cmd_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            cmd_next  = head;
            pos_next  = head.hdr ? POS_VERSION : POS_PAYLOAD;
        end
        else if (out_fire)
        begin
            if (at_payload)
            begin
                busy_next = 1'b0;
            end
            else if (pos_reg == POS_SSRC_0)
            begin
                pos_next = cmd_reg.fu ? POS_FU_IND : POS_PAYLOAD;
            end
            else
            begin
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    always_comb
    begin
        case (pos_reg)
            POS_VERSION: out_data.out_byte = RTP_VERSION_BYTE;
            POS_PT:      out_data.out_byte = {1'b0, payload_type};
            POS_SEQ_HI:  out_data.out_byte = cmd_reg.seq[15:8];
            POS_SEQ_LO:  out_data.out_byte = cmd_reg.seq[7:0];
            POS_TS_3:    out_data.out_byte = cmd_reg.ts[31:24];
            POS_TS_2:    out_data.out_byte = cmd_reg.ts[23:16];
            POS_TS_1:    out_data.out_byte = cmd_reg.ts[15:8];
            POS_TS_0:    out_data.out_byte = cmd_reg.ts[7:0];
            POS_SSRC_3:  out_data.out_byte = ssrc[31:24];
            POS_SSRC_2:  out_data.out_byte = ssrc[23:16];
            POS_SSRC_1:  out_data.out_byte = ssrc[15:8];
            POS_SSRC_0:  out_data.out_byte = ssrc[7:0];
            POS_FU_IND:  out_data.out_byte = FU_INDICATOR;
            POS_FU_HDR:  out_data.out_byte = cmd_reg.fu_hdr;
            default:     out_data.out_byte = cmd_reg.data;
        endcase
        out_data.packet_last   = at_payload && cmd_reg.last;
        out_data.packet_length = cmd_reg.pkt_len;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= POS_PAYLOAD;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rtpfu_checker.sv
// Port-level checker for the packetizer and its bind to the top level.
`default_nettype none

module rtpfu_checker
    import rtpfu_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire rtpfu_in_t  in_data,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire rtpfu_out_t out_data,
    input wire logic       cfg_wr_en
);

    logic hdr_due_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_due_reg <= 1'b1;
        end
        else if (out_valid && out_ready)
        begin
            hdr_due_reg <= out_data.packet_last;
        end
    end

    // A stalled output byte must be held until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output request changed while stalled");

    // A waiting input request must be held until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input request changed while stalled");

    // Every packet carries at least one payload byte and fits the largest fragment.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.packet_length >= 11'd13 && out_data.packet_length <= 11'd1474)
        else $error("packet length out of range");

    // After a completed packet the next byte must open an RTP header.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hdr_due_reg |-> out_data.out_byte == RTP_VERSION_BYTE
            && !out_data.packet_last)
        else $error("packet does not start with an RTP header");

    // Registers are written only while no packet byte is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |-> !out_valid)
        else $error("register written while a packet byte is pending");

endmodule

bind rtp_h264_fu_a_packetizer rtpfu_checker u_checker (.*);

`default_nettype wire
